FILE: sv/frs_pkg.sv
// ============================================================================
// frs_pkg: shared definitions for the fitness rank sorter
// Operation codes, register map and default sizes.
// ============================================================================
package frs_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int DEF_MAX_POPULATION = 256;
    localparam int DEF_FITNESS_WIDTH  = 32;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SORT   = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    // Register map: register index is the word address.
    localparam logic REG_POPULATION_SIZE = 1'b0;

    // Reset value of the population size register.
    localparam logic [8:0] POP_RESET = 9'd256;

endpackage

FILE: sv/frs_rank_mem.sv
// ============================================================================
// frs_rank_mem: rank table storage
// One write port and one registered read port. A per-entry valid bit makes
// an entry that was never written read as its own index (identity order).
// ============================================================================
module frs_rank_mem #(
    parameter int DEPTH = 256,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [IW-1:0] rd_addr,
    output logic [IW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  logic [IW-1:0] wr_data
);

    logic [IW-1:0] mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [IW-1:0] data_reg;
    logic [IW-1:0] addr_reg;
    logic          hit_reg;

    // Storage array: written and read at one address each cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        data_reg <= mem[rd_addr];
        addr_reg <= rd_addr;
    end

    // Valid bits are cleared by reset and set by the first write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            hit_reg <= vld_reg[rd_addr];
        end
    end

    // An unwritten entry reads as its own index.
    assign rd_data = hit_reg ? data_reg : addr_reg;

endmodule

FILE: sv/fitness_rank_sorter.sv
// ============================================================================
// fitness_rank_sorter: fitness store with a rank table ordered by fitness
// Load, sort, update-and-reposition and read on a shared compare sequencer.
// ============================================================================
// Usage:
//   Input transactions (operation, individual, fitness_value, rank_slot)
//   enter on in_valid/in_ready; each yields exactly one result transaction
//   (ranked_individual, new_position, out_of_range) on out_valid/out_ready.
//   population_size is written over the APB port at byte address 0.
//   sort: insertion sort of the rank table by fitness over the effective
//   population size; update: a search of the rank table for the individual,
//   then moves of its entry up or down to its place.
//   The pace is set by the single registered read port of the rank table
//   and of the fitness store, and by the one shared signed comparator.
// One transaction is worked on at a time; in_ready is high only when idle.
// A finished result waits in the output register; while the receiver
// stalls, the next transaction may be accepted and runs up to its result.
// Reset empties the output, sets population_size to 256 and makes the rank
// table the identity at once; the fitness store is undefined until loaded.
module fitness_rank_sorter
    import frs_pkg::*;
#(
    parameter int MAX_POPULATION = DEF_MAX_POPULATION,
    parameter int FITNESS_WIDTH  = DEF_FITNESS_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  individual,
    input  logic signed [31:0] fitness_value,
    input  logic [7:0]  rank_slot,
    // Output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  ranked_individual,
    output logic [7:0]  new_position,
    output logic        out_of_range
);

    localparam int IW = $clog2(MAX_POPULATION);
    localparam int NW = IW + 1;
    localparam int FW = FITNESS_WIDTH;
    localparam logic signed [63:0] FIT_HI = (64'sd1 <<< (FW - 1)) - 64'sd1;
    localparam logic signed [63:0] FIT_LO = -FIT_HI - 64'sd1;

    // Sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DONE  = 5'd1;
    localparam logic [4:0] S_RDD   = 5'd2;
    localparam logic [4:0] S_SK0   = 5'd3;
    localparam logic [4:0] S_SK1   = 5'd4;
    localparam logic [4:0] S_SK2   = 5'd5;
    localparam logic [4:0] S_SP0   = 5'd6;
    localparam logic [4:0] S_SP1   = 5'd7;
    localparam logic [4:0] S_SCMP  = 5'd8;
    localparam logic [4:0] S_SRCH  = 5'd9;
    localparam logic [4:0] S_SRCHD = 5'd10;
    localparam logic [4:0] S_UP0   = 5'd11;
    localparam logic [4:0] S_UP1   = 5'd12;
    localparam logic [4:0] S_UCMP  = 5'd13;
    localparam logic [4:0] S_DN0   = 5'd14;
    localparam logic [4:0] S_DN1   = 5'd15;
    localparam logic [4:0] S_DCMP  = 5'd16;
    localparam logic [4:0] S_FIN   = 5'd17;

    logic [4:0]  state_reg, state_next;
    logic [8:0]  pop_reg;
    logic [NW-1:0] n_reg, n_next, n_eff;
    logic [NW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic [IW-1:0] key_reg, key_next;
    logic [IW-1:0] pred_reg, pred_next;
    logic signed [FW-1:0] keyfit_reg, keyfit_next;
    logic [7:0]  res_rank_reg, res_rank_next;
    logic [7:0]  res_pos_reg, res_pos_next;
    logic        res_err_reg, res_err_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_rank_reg, out_rank_next;
    logic [7:0]  out_pos_reg, out_pos_next;
    logic        out_err_reg, out_err_next;

    logic [IW-1:0] rank_rd_addr, rank_rd_data, rank_wr_addr, rank_wr_data;
    logic          rank_wr_en;
    logic [IW-1:0] fit_rd_addr, fit_wr_addr;
    logic signed [FW-1:0] fit_wr_data, fit_rd_reg, fit_sat;
    logic          fit_wr_en;
    logic signed [FW-1:0] fit_mem [MAX_POPULATION];

    logic          cmp_lt, cmp_eq;
    logic [NW-1:0] i_inc, pos_inc;
    logic          ind_bad, slot_bad;
    logic signed [63:0] fv_wide;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = 32'(pop_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop_reg <= POP_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_POPULATION_SIZE))
        begin
            pop_reg <= pwdata[8:0];
        end
    end

    // Effective population size, saturated to the table depth.
    always_comb
    begin
        if (int'(pop_reg) > MAX_POPULATION)
        begin
            n_eff = NW'(MAX_POPULATION);
        end
        else
        begin
            n_eff = NW'(pop_reg);
        end
    end

    // Saturate the incoming fitness to the stored width.
    always_comb
    begin
        fv_wide = 64'(fitness_value);
        if (fv_wide > FIT_HI)
        begin
            fit_sat = FW'(FIT_HI);
        end
        else if (fv_wide < FIT_LO)
        begin
            fit_sat = FW'(FIT_LO);
        end
        else
        begin
            fit_sat = FW'(fv_wide);
        end
    end

    assign ind_bad  = int'(individual) >= int'(n_eff);
    assign slot_bad = int'(rank_slot) >= int'(n_eff);

    // Fitness store with a registered read port.
    always_ff @(posedge clk)
    begin
        if (fit_wr_en)
        begin
            fit_mem[fit_wr_addr] <= fit_wr_data;
        end
        fit_rd_reg <= fit_mem[fit_rd_addr];
    end

    // Rank table
    frs_rank_mem #(
        .DEPTH (MAX_POPULATION),
        .IW    (IW)
    ) u_rank (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rank_rd_addr),
        .rd_data (rank_rd_data),
        .wr_en   (rank_wr_en),
        .wr_addr (rank_wr_addr),
        .wr_data (rank_wr_data)
    );

    // Shared signed comparator: held key fitness against the fitness read.
    assign cmp_lt = keyfit_reg < fit_rd_reg;
    assign cmp_eq = keyfit_reg == fit_rd_reg;

    assign i_inc   = i_reg + NW'(1);
    assign pos_inc = {1'b0, pos_reg} + NW'(1);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        pos_next      = pos_reg;
        key_next      = key_reg;
        pred_next     = pred_reg;
        keyfit_next   = keyfit_reg;
        res_rank_next = res_rank_reg;
        res_pos_next  = res_pos_reg;
        res_err_next  = res_err_reg;
        rank_rd_addr  = IW'(i_reg);
        rank_wr_en    = 1'b0;
        rank_wr_addr  = j_reg;
        rank_wr_data  = key_reg;
        fit_rd_addr   = rank_rd_data;
        fit_wr_en     = 1'b0;
        fit_wr_addr   = IW'(individual);
        fit_wr_data   = fit_sat;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    n_next        = n_eff;
                    res_rank_next = '0;
                    res_pos_next  = '0;
                    res_err_next  = 1'b0;
                    i_next        = '0;
                    key_next      = IW'(individual);
                    keyfit_next   = fit_sat;
                    rank_rd_addr  = IW'(rank_slot);
                    unique case (operation)
                        OP_LOAD:
                        begin
                            res_err_next = ind_bad;
                            fit_wr_en    = !ind_bad;
                            state_next   = S_DONE;
                        end
                        OP_SORT:
                        begin
                            i_next     = NW'(1);
                            state_next = (n_eff <= NW'(1)) ? S_DONE : S_SK0;
                        end
                        OP_UPDATE:
                        begin
                            res_err_next = ind_bad;
                            fit_wr_en    = !ind_bad;
                            state_next   = ind_bad ? S_DONE : S_SRCH;
                        end
                        OP_READ:
                        begin
                            res_err_next = slot_bad;
                            state_next   = slot_bad ? S_DONE : S_RDD;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RDD:
            begin
                res_rank_next = 8'(rank_rd_data);
                state_next    = S_DONE;
            end
            // Sort: fetch the key entry and its fitness.
            S_SK0:
            begin
                rank_rd_addr = IW'(i_reg);
                state_next   = S_SK1;
            end
            S_SK1:
            begin
                key_next    = rank_rd_data;
                fit_rd_addr = rank_rd_data;
                j_next      = IW'(i_reg);
                state_next  = S_SK2;
            end
            S_SK2:
            begin
                keyfit_next = fit_rd_reg;
                state_next  = S_SP0;
            end
            // Sort: fetch the predecessor or drop the key in place.
            S_SP0:
            begin
                if (j_reg == '0)
                begin
                    rank_wr_en   = 1'b1;
                    rank_wr_addr = j_reg;
                    rank_wr_data = key_reg;
                    i_next       = i_inc;
                    state_next   = (i_inc == n_reg) ? S_DONE : S_SK0;
                end
                else
                begin
                    rank_rd_addr = IW'(j_reg - 1'b1);
                    state_next   = S_SP1;
                end
            end
            S_SP1:
            begin
                pred_next   = rank_rd_data;
                fit_rd_addr = rank_rd_data;
                state_next  = S_SCMP;
            end
            // Sort: shift the predecessor up when the key must come first.
            S_SCMP:
            begin
                rank_wr_en   = 1'b1;
                rank_wr_addr = j_reg;
                if (cmp_lt || (cmp_eq && (key_reg < pred_reg)))
                begin
                    rank_wr_data = pred_reg;
                    j_next       = IW'(j_reg - 1'b1);
                    state_next   = S_SP0;
                end
                else
                begin
                    rank_wr_data = key_reg;
                    i_next       = i_inc;
                    state_next   = (i_inc == n_reg) ? S_DONE : S_SK0;
                end
            end
            // Update: search the rank table for the individual.
            S_SRCH:
            begin
                rank_rd_addr = IW'(i_reg);
                state_next   = S_SRCHD;
            end
            S_SRCHD:
            begin
                if (rank_rd_data == key_reg)
                begin
                    pos_next   = IW'(i_reg);
                    state_next = S_UP0;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = (i_inc == n_reg) ? S_DONE : S_SRCH;
                end
            end
            // Update: move up while the predecessor is strictly greater.
            S_UP0:
            begin
                if (pos_reg == '0)
                begin
                    state_next = S_DN0;
                end
                else
                begin
                    rank_rd_addr = IW'(pos_reg - 1'b1);
                    state_next   = S_UP1;
                end
            end
            S_UP1:
            begin
                pred_next   = rank_rd_data;
                fit_rd_addr = rank_rd_data;
                state_next  = S_UCMP;
            end
            S_UCMP:
            begin
                if (cmp_lt)
                begin
                    rank_wr_en   = 1'b1;
                    rank_wr_addr = pos_reg;
                    rank_wr_data = pred_reg;
                    pos_next     = IW'(pos_reg - 1'b1);
                    state_next   = S_UP0;
                end
                else
                begin
                    state_next = S_DN0;
                end
            end
            // Update: move down while the successor is strictly less.
            S_DN0:
            begin
                if (pos_inc >= n_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    rank_rd_addr = IW'(pos_inc);
                    state_next   = S_DN1;
                end
            end
            S_DN1:
            begin
                pred_next   = rank_rd_data;
                fit_rd_addr = rank_rd_data;
                state_next  = S_DCMP;
            end
            S_DCMP:
            begin
                if (!cmp_lt && !cmp_eq)
                begin
                    rank_wr_en   = 1'b1;
                    rank_wr_addr = pos_reg;
                    rank_wr_data = pred_reg;
                    pos_next     = IW'(pos_inc);
                    state_next   = S_DN0;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            // Update: place the individual at its final slot.
            S_FIN:
            begin
                rank_wr_en   = 1'b1;
                rank_wr_addr = pos_reg;
                rank_wr_data = key_reg;
                res_pos_next = 8'(pos_reg);
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: loaded when a result is finished and the slot is free.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_rank_next  = out_rank_reg;
        out_pos_next   = out_pos_reg;
        out_err_next   = out_err_reg;
        if ((state_reg == S_DONE) && (!out_valid_reg || out_ready))
        begin
            out_valid_next = 1'b1;
            out_rank_next  = res_rank_reg;
            out_pos_next   = res_pos_reg;
            out_err_next   = res_err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        pos_reg      <= pos_next;
        key_reg      <= key_next;
        pred_reg     <= pred_next;
        keyfit_reg   <= keyfit_next;
        res_rank_reg <= res_rank_next;
        res_pos_reg  <= res_pos_next;
        res_err_reg  <= res_err_next;
        out_rank_reg <= out_rank_next;
        out_pos_reg  <= out_pos_next;
        out_err_reg  <= out_err_next;
    end

    assign in_ready          = (state_reg == S_IDLE);
    assign out_valid         = out_valid_reg;
    assign ranked_individual = out_rank_reg;
    assign new_position      = out_pos_reg;
    assign out_of_range      = out_err_reg;

endmodule
